/* rtl/utf8_to_cp437_translate_macros.svh */
// assertion macros for the utf8 to code page 437 translator
// no dependencies; included by the checker file
`ifndef UTF8_TO_CP437_TRANSLATE_MACROS_SVH
`define UTF8_TO_CP437_TRANSLATE_MACROS_SVH

// property sampled on the rising clock edge, off while reset is low
`define U8CP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication form built on the macro above
`define U8CP_ASSERT_IMPLY(label, ante, cons, msg) \
	`U8CP_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* rtl/utf8cp_pkg.sv */
// shared types and constants for the utf8 to code page 437 translator
// no dependencies
package utf8cp_pkg;

	// one three byte window in, one translated character out
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
	} in_t;

	typedef struct packed {
		logic [7:0] cp437_char;
		logic [1:0] bytes_used;
	} out_t;

	// table lookup outcome: hit flag and mapped character
	typedef struct packed {
		logic       hit;
		logic [7:0] ch;
	} map_t;

	localparam logic [7:0] ASCII_MAX  = 8'd127;
	localparam logic [7:0] LEAD_C2    = 8'hC2;
	localparam logic [7:0] LEAD_C3    = 8'hC3;
	localparam logic [7:0] LEAD_C6    = 8'hC6;
	localparam logic [7:0] LEAD_CE    = 8'hCE;
	localparam logic [7:0] LEAD_CF    = 8'hCF;
	localparam logic [7:0] LEAD_E2    = 8'hE2;
	localparam logic [7:0] E2_MID_81  = 8'h81;
	localparam logic [7:0] E2_MID_82  = 8'h82;
	localparam logic [7:0] E2_MID_88  = 8'h88;
	localparam logic [7:0] E2_MID_89  = 8'h89;
	localparam logic [7:0] E2_MID_8C  = 8'h8C;
	localparam logic [7:0] E2_MID_94  = 8'h94;
	localparam logic [7:0] E2_MID_95  = 8'h95;
	localparam logic [7:0] E2_MID_96  = 8'h96;

	localparam logic [1:0] USED_ONE   = 2'd1;
	localparam logic [1:0] USED_TWO   = 2'd2;
	localparam logic [1:0] USED_THREE = 2'd3;

	localparam logic [7:0] REPL_RESET = 8'd63;

endpackage

/* rtl/utf8cp_map.sv */
// combinational translation of one registered byte window
// depends on utf8cp_pkg
module utf8cp_map (
	input  utf8cp_pkg::in_t   item,
	input  logic [7:0]        repl,
	output utf8cp_pkg::out_t  result
);
	import utf8cp_pkg::*;

	function automatic map_t hit(input logic [7:0] c);
		map_t r;
		r.hit = 1'b1;
		r.ch  = c;
		return r;
	endfunction

	// two byte sequences, keyed by lead and continuation
	function automatic map_t map_two(input logic [7:0] lead, input logic [7:0] b);
		map_t r;
		r = '0;
		case (lead)
			LEAD_C2: begin
				case (b)
					8'hA2: r = hit(8'd155);
					8'hA3: r = hit(8'd156);
					8'hA5: r = hit(8'd157);
					8'hAA: r = hit(8'd166);
					8'hBA: r = hit(8'd167);
					8'hBF: r = hit(8'd168);
					8'hAC: r = hit(8'd170);
					8'hBD: r = hit(8'd171);
					8'hBC: r = hit(8'd172);
					8'hA1: r = hit(8'd173);
					8'hAB: r = hit(8'd174);
					8'hBB: r = hit(8'd175);
					8'hB5: r = hit(8'd230);
					8'hB1: r = hit(8'd241);
					8'hB0: r = hit(8'd248);
					8'hB7: r = hit(8'd250);
					8'hB2: r = hit(8'd253);
					8'hA0: r = hit(8'd255);
					default: r = '0;
				endcase
			end
			LEAD_C3: begin
				case (b)
					8'h87: r = hit(8'd128);
					8'hBC: r = hit(8'd129);
					8'hA9: r = hit(8'd130);
					8'hA2: r = hit(8'd131);
					8'hA4: r = hit(8'd132);
					8'hA0: r = hit(8'd133);
					8'hA5: r = hit(8'd134);
					8'hA7: r = hit(8'd135);
					8'hAA: r = hit(8'd136);
					8'hAB: r = hit(8'd137);
					8'hA8: r = hit(8'd138);
					8'hAF: r = hit(8'd139);
					8'hAE: r = hit(8'd140);
					8'hAC: r = hit(8'd141);
					8'h84: r = hit(8'd142);
					8'h85: r = hit(8'd143);
					8'h89: r = hit(8'd144);
					8'hA6: r = hit(8'd145);
					8'h86: r = hit(8'd146);
					8'hB4: r = hit(8'd147);
					8'hB6: r = hit(8'd148);
					8'hB2: r = hit(8'd149);
					8'hBB: r = hit(8'd150);
					8'hB9: r = hit(8'd151);
					8'hBF: r = hit(8'd152);
					8'h96: r = hit(8'd153);
					8'h9C: r = hit(8'd154);
					8'hA1: r = hit(8'd160);
					8'hAD: r = hit(8'd161);
					8'hB3: r = hit(8'd162);
					8'hBA: r = hit(8'd163);
					8'hB1: r = hit(8'd164);
					8'h91: r = hit(8'd165);
					8'h9F: r = hit(8'd225);
					8'hB7: r = hit(8'd246);
					default: r = '0;
				endcase
			end
			LEAD_C6: begin
				case (b)
					8'h92: r = hit(8'd159);
					default: r = '0;
				endcase
			end
			LEAD_CE: begin
				case (b)
					8'hB1: r = hit(8'd224);
					8'h93: r = hit(8'd226);
					8'hA3: r = hit(8'd228);
					8'hA6: r = hit(8'd232);
					8'h98: r = hit(8'd233);
					8'hA9: r = hit(8'd234);
					8'hB4: r = hit(8'd235);
					8'hB5: r = hit(8'd238);
					default: r = '0;
				endcase
			end
			LEAD_CF: begin
				case (b)
					8'h80: r = hit(8'd227);
					8'hA3: r = hit(8'd228);
					8'h83: r = hit(8'd229);
					8'h84: r = hit(8'd231);
					8'h86: r = hit(8'd237);
					default: r = '0;
				endcase
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// three byte sequences after an E2 lead
	function automatic map_t map_e2(input logic [7:0] mid, input logic [7:0] b);
		map_t r;
		r = '0;
		case (mid)
			E2_MID_82: begin
				case (b)
					8'hA7: r = hit(8'd158);
					default: r = '0;
				endcase
			end
			E2_MID_96: begin
				case (b)
					8'h91: r = hit(8'd176);
					8'h92: r = hit(8'd177);
					8'h93: r = hit(8'd178);
					8'h88: r = hit(8'd219);
					8'h84: r = hit(8'd220);
					8'h8C: r = hit(8'd221);
					8'h90: r = hit(8'd222);
					8'h80: r = hit(8'd223);
					8'hA0: r = hit(8'd254);
					default: r = '0;
				endcase
			end
			E2_MID_94: begin
				case (b)
					8'h82: r = hit(8'd179);
					8'hA4: r = hit(8'd180);
					8'h90: r = hit(8'd191);
					8'h94: r = hit(8'd192);
					8'hB4: r = hit(8'd193);
					8'hAC: r = hit(8'd194);
					8'h9C: r = hit(8'd195);
					8'h80: r = hit(8'd196);
					8'hBC: r = hit(8'd197);
					8'h98: r = hit(8'd217);
					8'h8C: r = hit(8'd218);
					default: r = '0;
				endcase
			end
			E2_MID_95: begin
				case (b)
					8'hA1: r = hit(8'd181);
					8'hA2: r = hit(8'd182);
					8'h96: r = hit(8'd183);
					8'h95: r = hit(8'd184);
					8'hA3: r = hit(8'd185);
					8'h91: r = hit(8'd186);
					8'h97: r = hit(8'd187);
					8'h9D: r = hit(8'd188);
					8'h9C: r = hit(8'd189);
					8'h9B: r = hit(8'd190);
					8'h9E: r = hit(8'd198);
					8'h9F: r = hit(8'd199);
					8'h9A: r = hit(8'd200);
					8'h94: r = hit(8'd201);
					8'hA9: r = hit(8'd202);
					8'hA6: r = hit(8'd203);
					8'hA0: r = hit(8'd204);
					8'h90: r = hit(8'd205);
					8'hAC: r = hit(8'd206);
					8'hA7: r = hit(8'd207);
					8'hA8: r = hit(8'd208);
					8'hA4: r = hit(8'd209);
					8'hA5: r = hit(8'd210);
					8'h99: r = hit(8'd211);
					8'h98: r = hit(8'd212);
					8'h92: r = hit(8'd213);
					8'h93: r = hit(8'd214);
					8'hAB: r = hit(8'd215);
					8'hAA: r = hit(8'd216);
					default: r = '0;
				endcase
			end
			E2_MID_88: begin
				case (b)
					8'h9E: r = hit(8'd236);
					8'hA9: r = hit(8'd239);
					8'h99: r = hit(8'd249);
					8'h9A: r = hit(8'd251);
					default: r = '0;
				endcase
			end
			E2_MID_89: begin
				case (b)
					8'hA1: r = hit(8'd240);
					8'hA5: r = hit(8'd242);
					8'hA4: r = hit(8'd243);
					8'h88: r = hit(8'd247);
					default: r = '0;
				endcase
			end
			E2_MID_8C: begin
				case (b)
					8'h90: r = hit(8'd169);
					8'hA0: r = hit(8'd244);
					8'hA1: r = hit(8'd245);
					default: r = '0;
				endcase
			end
			E2_MID_81: begin
				case (b)
					8'hBF: r = hit(8'd252);
					default: r = '0;
				endcase
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	map_t two_m;
	map_t e2_m;

	// table lookups run in parallel, lead byte picks one
	assign two_m = map_two(item.byte0, item.byte1);
	assign e2_m  = map_e2(item.byte1, item.byte2);

	always_comb begin
		if (item.byte0 <= ASCII_MAX) begin
			result.cp437_char = item.byte0;
			result.bytes_used = USED_ONE;
		end else if (item.byte0 == LEAD_E2) begin
			result.cp437_char = e2_m.hit ? e2_m.ch : repl;
			result.bytes_used = USED_THREE;
		end else if (item.byte0 == LEAD_C2 || item.byte0 == LEAD_C3 ||
				item.byte0 == LEAD_C6 || item.byte0 == LEAD_CE ||
				item.byte0 == LEAD_CF) begin
			result.cp437_char = two_m.hit ? two_m.ch : repl;
			result.bytes_used = USED_TWO;
		end else begin
			// unsupported lead or stray continuation
			result.cp437_char = repl;
			result.bytes_used = USED_ONE;
		end
	end

endmodule

/* rtl/utf8_to_cp437_translate.sv */
// utf8 to code page 437 translator: the window is held in the input register, then
// the result register takes the result; throughput 1 window per cycle, set by the
// single table lookup between the input register and the result register.
// busy stays low, so a new window is taken every cycle; results cannot stall.
// arst_n clears the valid flags and loads the replacement character with 63.
// depends on utf8cp_pkg and utf8cp_map
module utf8_to_cp437_translate (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  utf8cp_pkg::in_t    item,
	output logic               done,
	output utf8cp_pkg::out_t   result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);
	import utf8cp_pkg::*;

	logic       valid_s1;
	in_t        item_s1;
	logic [7:0] repl_q;
	out_t       map_out;
	out_t       result_q;
	logic       done_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// replacement character register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			repl_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	utf8cp_map u_map (
		.item   (item_s1),
		.repl   (repl_q),
		.result (map_out)
	);

	// result register, strobe for one cycle per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= map_out;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* rtl/utf8cp_checker.sv */
// port level checks for the utf8 to code page 437 translator, bound to the top
// depends on utf8cp_pkg and utf8_to_cp437_translate_macros.svh
`include "utf8_to_cp437_translate_macros.svh"

module utf8cp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input utf8cp_pkg::in_t   item,
	input logic              done,
	input utf8cp_pkg::out_t  result
);
	import utf8cp_pkg::*;

	// every accepted window gives a result once it has passed the input and result registers
	`U8CP_ASSERT_IMPLY(a_result_follows, start && !busy, ##2 done, "accepted window gave no result")

	// no result without a transaction that passed the input and result registers
	`U8CP_ASSERT_IMPLY(a_no_spurious, done, $past(start && !busy, 2), "result without a transaction")

	// consumed count stays in range
	`U8CP_ASSERT_IMPLY(a_used_range, done, result.bytes_used != 2'd0, "bytes used out of range")

	// ascii passes through using one byte
	`U8CP_ASSERT_IMPLY(a_ascii_pass, done && $past(start && !busy && !item.byte0[7], 2), (result.cp437_char == $past(item.byte0, 2)) && (result.bytes_used == USED_ONE), "ascii byte not passed through")

endmodule

bind utf8_to_cp437_translate utf8cp_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

/* test/tb.sv */
// testbench for utf8_to_cp437_translate: directed windows, then random phases per replacement char
// depends on utf8cp_pkg and the translator rtl; self-checking through an internal predictor
`timescale 1ns / 100ps

module tb;
	import utf8cp_pkg::*;

	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS   = 240;
	localparam int STALL_LIMIT   = 2000;

	// one row of the directed plan: window, and a hand-written result where one is given
	typedef struct {
		in_t  win;
		bit   typed;
		out_t want;
	} plan_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	in_t        item = '0;
	logic       done;
	out_t       result;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;

	out_t       pending_chars[$];
	logic [7:0] repl_now = REPL_RESET;
	int         errors = 0;
	int         windows_sent = 0;
	int         chars_seen = 0;
	int         repl_writes = 0;
	int         idle_cycles = 0;

	// directed windows, typed results assume the reset replacement char
	plan_row_t plan [25] = '{
		'{'{8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, USED_ONE}},
		'{'{ASCII_MAX, 8'hFF, 8'hFF}, 1'b1, '{ASCII_MAX, USED_ONE}},
		'{'{8'h41, LEAD_C2, 8'hA2}, 1'b1, '{8'h41, USED_ONE}},
		'{'{8'h80, 8'h80, 8'h80}, 1'b1, '{REPL_RESET, USED_ONE}},
		'{'{8'hFF, 8'hFF, 8'hFF}, 1'b1, '{REPL_RESET, USED_ONE}},
		'{'{8'hC1, 8'hA2, 8'h00}, 1'b1, '{REPL_RESET, USED_ONE}},
		'{'{8'hE3, E2_MID_82, 8'hA7}, 1'b1, '{REPL_RESET, USED_ONE}},
		'{'{LEAD_C2, 8'hA2, 8'h00}, 1'b0, '0},
		'{'{LEAD_C2, 8'h00, 8'hFF}, 1'b1, '{REPL_RESET, USED_TWO}},
		'{'{LEAD_C3, 8'h87, 8'h55}, 1'b0, '0},
		'{'{LEAD_C3, 8'hFF, 8'h00}, 1'b1, '{REPL_RESET, USED_TWO}},
		'{'{LEAD_C6, 8'h92, 8'h00}, 1'b0, '0},
		'{'{LEAD_CE, 8'hB1, 8'hAA}, 1'b0, '0},
		'{'{LEAD_CF, 8'h86, 8'h00}, 1'b0, '0},
		'{'{LEAD_CF, 8'hA0, 8'h00}, 1'b1, '{REPL_RESET, USED_TWO}},
		'{'{LEAD_E2, E2_MID_82, 8'hA7}, 1'b0, '0},
		'{'{LEAD_E2, E2_MID_96, 8'hA0}, 1'b0, '0},
		'{'{LEAD_E2, E2_MID_94, 8'h8C}, 1'b0, '0},
		'{'{LEAD_E2, E2_MID_95, 8'hAA}, 1'b0, '0},
		'{'{LEAD_E2, E2_MID_88, 8'h9E}, 1'b0, '0},
		'{'{LEAD_E2, E2_MID_89, 8'h88}, 1'b0, '0},
		'{'{LEAD_E2, E2_MID_8C, 8'hA1}, 1'b0, '0},
		'{'{LEAD_E2, E2_MID_81, 8'hBF}, 1'b0, '0},
		'{'{LEAD_E2, 8'h00, 8'h00}, 1'b1, '{REPL_RESET, USED_THREE}},
		'{'{LEAD_E2, E2_MID_95, 8'hFF}, 1'b1, '{REPL_RESET, USED_THREE}}
	};

	utf8_to_cp437_translate DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// lead byte plus one continuation byte
	function automatic map_t map_two_byte(input logic [7:0] lead, input logic [7:0] cont);
		map_t m;
		m.hit = 1'b1;
		m.ch = 8'h00;
		case (lead)
		LEAD_C2: case (cont)
			8'hA2: m.ch = 8'd155; 8'hA3: m.ch = 8'd156; 8'hA5: m.ch = 8'd157;
			8'hAA: m.ch = 8'd166; 8'hBA: m.ch = 8'd167; 8'hBF: m.ch = 8'd168;
			8'hAC: m.ch = 8'd170; 8'hBD: m.ch = 8'd171; 8'hBC: m.ch = 8'd172;
			8'hA1: m.ch = 8'd173; 8'hAB: m.ch = 8'd174; 8'hBB: m.ch = 8'd175;
			8'hB5: m.ch = 8'd230; 8'hB1: m.ch = 8'd241; 8'hB0: m.ch = 8'd248;
			8'hB7: m.ch = 8'd250; 8'hB2: m.ch = 8'd253; 8'hA0: m.ch = 8'd255;
			default: m.hit = 1'b0;
		endcase
		LEAD_C3: case (cont)
			8'h87: m.ch = 8'd128; 8'hBC: m.ch = 8'd129; 8'hA9: m.ch = 8'd130;
			8'hA2: m.ch = 8'd131; 8'hA4: m.ch = 8'd132; 8'hA0: m.ch = 8'd133;
			8'hA5: m.ch = 8'd134; 8'hA7: m.ch = 8'd135; 8'hAA: m.ch = 8'd136;
			8'hAB: m.ch = 8'd137; 8'hA8: m.ch = 8'd138; 8'hAF: m.ch = 8'd139;
			8'hAE: m.ch = 8'd140; 8'hAC: m.ch = 8'd141; 8'h84: m.ch = 8'd142;
			8'h85: m.ch = 8'd143; 8'h89: m.ch = 8'd144; 8'hA6: m.ch = 8'd145;
			8'h86: m.ch = 8'd146; 8'hB4: m.ch = 8'd147; 8'hB6: m.ch = 8'd148;
			8'hB2: m.ch = 8'd149; 8'hBB: m.ch = 8'd150; 8'hB9: m.ch = 8'd151;
			8'hBF: m.ch = 8'd152; 8'h96: m.ch = 8'd153; 8'h9C: m.ch = 8'd154;
			8'hA1: m.ch = 8'd160; 8'hAD: m.ch = 8'd161; 8'hB3: m.ch = 8'd162;
			8'hBA: m.ch = 8'd163; 8'hB1: m.ch = 8'd164; 8'h91: m.ch = 8'd165;
			8'h9F: m.ch = 8'd225; 8'hB7: m.ch = 8'd246;
			default: m.hit = 1'b0;
		endcase
		LEAD_C6: case (cont)
			8'h92: m.ch = 8'd159;
			default: m.hit = 1'b0;
		endcase
		LEAD_CE: case (cont)
			8'hB1: m.ch = 8'd224; 8'h93: m.ch = 8'd226; 8'hA3: m.ch = 8'd228;
			8'hA6: m.ch = 8'd232; 8'h98: m.ch = 8'd233; 8'hA9: m.ch = 8'd234;
			8'hB4: m.ch = 8'd235; 8'hB5: m.ch = 8'd238;
			default: m.hit = 1'b0;
		endcase
		LEAD_CF: case (cont)
			8'h80: m.ch = 8'd227; 8'hA3: m.ch = 8'd228; 8'h83: m.ch = 8'd229;
			8'h84: m.ch = 8'd231; 8'h86: m.ch = 8'd237;
			default: m.hit = 1'b0;
		endcase
		default: m.hit = 1'b0;
		endcase
		return m;
	endfunction

	// three byte sequences after an E2 lead: box drawing, math and misc symbols
	function automatic map_t map_box_symbol(input logic [7:0] mid, input logic [7:0] last);
		map_t m;
		m.hit = 1'b1;
		m.ch = 8'h00;
		case (mid)
		E2_MID_82: case (last)
			8'hA7: m.ch = 8'd158;
			default: m.hit = 1'b0;
		endcase
		E2_MID_96: case (last)
			8'h91: m.ch = 8'd176; 8'h92: m.ch = 8'd177; 8'h93: m.ch = 8'd178;
			8'h88: m.ch = 8'd219; 8'h84: m.ch = 8'd220; 8'h8C: m.ch = 8'd221;
			8'h90: m.ch = 8'd222; 8'h80: m.ch = 8'd223; 8'hA0: m.ch = 8'd254;
			default: m.hit = 1'b0;
		endcase
		E2_MID_94: case (last)
			8'h82: m.ch = 8'd179; 8'hA4: m.ch = 8'd180; 8'h90: m.ch = 8'd191;
			8'h94: m.ch = 8'd192; 8'hB4: m.ch = 8'd193; 8'hAC: m.ch = 8'd194;
			8'h9C: m.ch = 8'd195; 8'h80: m.ch = 8'd196; 8'hBC: m.ch = 8'd197;
			8'h98: m.ch = 8'd217; 8'h8C: m.ch = 8'd218;
			default: m.hit = 1'b0;
		endcase
		E2_MID_95: case (last)
			8'hA1: m.ch = 8'd181; 8'hA2: m.ch = 8'd182; 8'h96: m.ch = 8'd183;
			8'h95: m.ch = 8'd184; 8'hA3: m.ch = 8'd185; 8'h91: m.ch = 8'd186;
			8'h97: m.ch = 8'd187; 8'h9D: m.ch = 8'd188; 8'h9C: m.ch = 8'd189;
			8'h9B: m.ch = 8'd190; 8'h9E: m.ch = 8'd198; 8'h9F: m.ch = 8'd199;
			8'h9A: m.ch = 8'd200; 8'h94: m.ch = 8'd201; 8'hA9: m.ch = 8'd202;
			8'hA6: m.ch = 8'd203; 8'hA0: m.ch = 8'd204; 8'h90: m.ch = 8'd205;
			8'hAC: m.ch = 8'd206; 8'hA7: m.ch = 8'd207; 8'hA8: m.ch = 8'd208;
			8'hA4: m.ch = 8'd209; 8'hA5: m.ch = 8'd210; 8'h99: m.ch = 8'd211;
			8'h98: m.ch = 8'd212; 8'h92: m.ch = 8'd213; 8'h93: m.ch = 8'd214;
			8'hAB: m.ch = 8'd215; 8'hAA: m.ch = 8'd216;
			default: m.hit = 1'b0;
		endcase
		E2_MID_88: case (last)
			8'h9E: m.ch = 8'd236; 8'hA9: m.ch = 8'd239; 8'h99: m.ch = 8'd249;
			8'h9A: m.ch = 8'd251;
			default: m.hit = 1'b0;
		endcase
		E2_MID_89: case (last)
			8'hA1: m.ch = 8'd240; 8'hA5: m.ch = 8'd242; 8'hA4: m.ch = 8'd243;
			8'h88: m.ch = 8'd247;
			default: m.hit = 1'b0;
		endcase
		E2_MID_8C: case (last)
			8'h90: m.ch = 8'd169; 8'hA0: m.ch = 8'd244; 8'hA1: m.ch = 8'd245;
			default: m.hit = 1'b0;
		endcase
		E2_MID_81: case (last)
			8'hBF: m.ch = 8'd252;
			default: m.hit = 1'b0;
		endcase
		default: m.hit = 1'b0;
		endcase
		return m;
	endfunction

	// expected character and byte count for one window
	function automatic out_t translate_window(input in_t w, input logic [7:0] repl);
		out_t r;
		map_t m;
		if (w.byte0 <= ASCII_MAX) begin
			r.cp437_char = w.byte0;
			r.bytes_used = USED_ONE;
		end else begin
			case (w.byte0)
			LEAD_C2, LEAD_C3, LEAD_C6, LEAD_CE, LEAD_CF: begin
				m = map_two_byte(w.byte0, w.byte1);
				r.cp437_char = m.hit ? m.ch : repl;
				r.bytes_used = USED_TWO;
			end
			LEAD_E2: begin
				m = map_box_symbol(w.byte1, w.byte2);
				r.cp437_char = m.hit ? m.ch : repl;
				r.bytes_used = USED_THREE;
			end
			default: begin
				// stray continuation or unsupported lead
				r.cp437_char = repl;
				r.bytes_used = USED_ONE;
			end
			endcase
		end
		return r;
	endfunction

	// mostly well-formed sequences, some broken ones, some pure noise
	function automatic in_t draw_window();
		in_t w;
		map_t m;
		int kind;
		w = {8'($urandom), 8'($urandom), 8'($urandom)};
		kind = $urandom_range(0, 99);
		m.hit = 1'b0;
		m.ch = 8'h00;
		if (kind < 25) begin
			w.byte0 = 8'($urandom_range(0, 127));
		end else if (kind < 55) begin
			case ($urandom_range(0, 4))
			0: w.byte0 = LEAD_C2;
			1: w.byte0 = LEAD_C3;
			2: w.byte0 = LEAD_C6;
			3: w.byte0 = LEAD_CE;
			default: w.byte0 = LEAD_CF;
			endcase
			for (int t = 0; t < 400 && !m.hit; t++) begin
				w.byte1 = 8'($urandom_range(8'h80, 8'hBF));
				m = map_two_byte(w.byte0, w.byte1);
			end
		end else if (kind < 80) begin
			w.byte0 = LEAD_E2;
			case ($urandom_range(0, 7))
			0: w.byte1 = E2_MID_81;
			1: w.byte1 = E2_MID_82;
			2: w.byte1 = E2_MID_88;
			3: w.byte1 = E2_MID_89;
			4: w.byte1 = E2_MID_8C;
			5: w.byte1 = E2_MID_94;
			6: w.byte1 = E2_MID_95;
			default: w.byte1 = E2_MID_96;
			endcase
			for (int t = 0; t < 400 && !m.hit; t++) begin
				w.byte2 = 8'($urandom_range(8'h80, 8'hBF));
				m = map_box_symbol(w.byte1, w.byte2);
			end
		end else if (kind < 90) begin
			// known lead with arbitrary trailing bytes
			case ($urandom_range(0, 5))
			0: w.byte0 = LEAD_C2;
			1: w.byte0 = LEAD_C3;
			2: w.byte0 = LEAD_C6;
			3: w.byte0 = LEAD_CE;
			4: w.byte0 = LEAD_CF;
			default: w.byte0 = LEAD_E2;
			endcase
		end
		return w;
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// present one window after a gap, wait for its transaction, queue the expected char
	task automatic send_window(input in_t w, input out_t want, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
		pending_chars.push_back(want);
		windows_sent++;
	endtask

	// hold off the sender until every queued char has come back
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	task automatic write_repl(input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		repl_now = value;
		repl_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		out_t want;
		if (arst_n && done) begin
			chars_seen++;
			if (pending_chars.size() == 0) begin
				report_error($sformatf("unexpected result char %h used %0d",
					result.cp437_char, result.bytes_used));
			end else begin
				want = pending_chars.pop_front();
				if (result.cp437_char !== want.cp437_char)
					report_error($sformatf("cp437_char got %h want %h",
						result.cp437_char, want.cp437_char));
				if (result.bytes_used !== want.bytes_used)
					report_error($sformatf("bytes_used got %0d want %0d",
						result.bytes_used, want.bytes_used));
			end
		end
	end

	// watchdog on cycles with no transaction of any kind
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		logic [7:0] repl_plan [RANDOM_PHASES];
		logic       burst;
		in_t        w;
		repl_plan = '{8'h00, 8'hFF, 8'($urandom), REPL_RESET, 8'($urandom)};
		burst = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed windows with the reset replacement char
		foreach (plan[i]) begin
			send_window(plan[i].win,
				plan[i].typed ? plan[i].want : translate_window(plan[i].win, repl_now),
				(i % 3 == 0) ? 0 : $urandom_range(0, 12));
		end
		drain_results();

		// random phases, one replacement char each
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_repl(repl_plan[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					burst = ($urandom_range(0, 3) == 0);
				if (n == PHASE_ITEMS / 2)
					drain_results();
				w = draw_window();
				send_window(w, translate_window(w, repl_now), burst ? 0 : $urandom_range(0, 12));
			end
			drain_results();
		end

		// allow any stray result to show up
		repeat (4) @(posedge clk);
		$display("%0d windows sent (%0d directed), %0d chars checked", windows_sent,
			$size(plan), chars_seen);
		$display("%0d replacement char writes, including 00 and ff", repl_writes);
		if (errors == 0 && pending_chars.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/utf8cp_pkg.sv
rtl/utf8cp_map.sv
rtl/utf8_to_cp437_translate.sv
rtl/utf8cp_checker.sv
test/tb.sv
